// File: rtl/hbw_pkg.sv
// ----------------------------------------------------------------------------
// hbw_pkg - shared types for the heartbeat watchdog
// Request and response beats, per-slot control and status, operation codes.
// ----------------------------------------------------------------------------
package hbw_pkg;

  localparam int unsigned MaxModules     = 8;
  localparam int unsigned ModuleCountDef = 8;
  localparam int unsigned CfgIdxW        = 8;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned TimeoutW       = 16;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd30;

  // operation codes, the spare code behaves as a query
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpBeat  = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] module_req;
  } hbw_req_t;

  typedef struct packed {
    logic [TimeW-1:0]    elapsed_seconds;
    logic [TimeoutW-1:0] module_timeout;
    logic                module_registered;
    logic [7:0]          expired_mask;
    logic                all_healthy;
  } hbw_rsp_t;

  typedef struct packed {
    logic beat;
    logic cfg_we;
  } slot_ctrl_t;

  typedef struct packed {
    logic [TimeW-1:0]    elapsed;
    logic [TimeoutW-1:0] timeout;
    logic                registered;
    logic                expired;
  } slot_stat_t;

endpackage

// File: rtl/multi_module_heartbeat_watchdog.sv
// ----------------------------------------------------------------------------
// multi_module_heartbeat_watchdog - heartbeat watchdog over up to eight modules
// Seconds counter, per-module heartbeat stamps and timeouts, expiry report.
// ----------------------------------------------------------------------------
// A command beat is taken on every cycle that start_i is high; busy_o stays
// low, so one beat per clock is sustained. Each beat gives exactly one
// response on rsp_o, marked by done_o, which is high for a single cycle,
// once the beat has gone through the command register, then through the
// state update and the per-module subtract-and-compare into the response
// register. The receiver cannot stall, so the response must be captured in
// the cycle done_o is high. Timeouts are written through the cfg channel,
// which is always ready; write them only while no command is in flight.
// After reset all timeouts are 30 and no module is registered.
module multi_module_heartbeat_watchdog #(
  parameter int unsigned MODULE_COUNT = hbw_pkg::ModuleCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  hbw_pkg::hbw_req_t             req_i,
  output logic                          done_o,
  output hbw_pkg::hbw_rsp_t             rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hbw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hbw_pkg::TimeoutW-1:0]  cfg_data_i
);
  import hbw_pkg::*;

  localparam logic [3:0] ModCnt = 4'(MODULE_COUNT);

  logic             valid_q;
  hbw_req_t         req_q;
  logic [TimeW-1:0] now_d, now_q;
  logic             tick, beat, in_range;
  slot_stat_t       stat [MaxModules];
  slot_stat_t       sel_stat;
  logic [7:0]       mask;
  logic             done_q;
  hbw_rsp_t         rsp_d, rsp_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
  end

  // decode and seconds counter
  assign in_range = {1'b0, req_q.module_req} < ModCnt;
  assign tick     = valid_q && (req_q.operation == OpTick);
  assign beat     = valid_q && (req_q.operation == OpBeat) && in_range;
  assign now_d    = now_q + {{(TimeW-1){1'b0}}, tick};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else begin
      now_q <= now_d;
    end
  end

  // one slot per watched module, absent slots read as zero
  for (genvar i = 0; i < MaxModules; i++) begin : g_slot
    if (i < MODULE_COUNT) begin : g_on
      slot_ctrl_t ctrl;
      always_comb begin
        ctrl.beat   = beat && (req_q.module_req == 3'(i));
        ctrl.cfg_we = cfg_valid_i && (cfg_index_i == CfgIdxW'(i));
      end
      hbw_slot u_slot (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .now_d_i    (now_d),
        .ctrl_i     (ctrl),
        .cfg_data_i (cfg_data_i),
        .stat_o     (stat[i])
      );
    end else begin : g_off
      assign stat[i] = '0;
    end
    assign mask[i] = stat[i].expired;
  end

  // response assembly
  always_comb begin
    sel_stat = in_range ? stat[req_q.module_req] : '0;
    rsp_d.elapsed_seconds   = sel_stat.elapsed;
    rsp_d.module_timeout    = sel_stat.timeout;
    rsp_d.module_registered = sel_stat.registered;
    rsp_d.expired_mask      = mask;
    rsp_d.all_healthy       = (mask == 8'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/hbw_slot.sv
// ----------------------------------------------------------------------------
// hbw_slot - one watched module
// Holds the timeout, last heartbeat stamp and registered flag of one module
// and reports its elapsed time and expiry as they stand after the update.
// ----------------------------------------------------------------------------
module hbw_slot (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [hbw_pkg::TimeW-1:0]        now_d_i,
  input  hbw_pkg::slot_ctrl_t              ctrl_i,
  input  logic [hbw_pkg::TimeoutW-1:0]     cfg_data_i,
  output hbw_pkg::slot_stat_t              stat_o
);
  import hbw_pkg::*;

  logic [TimeW-1:0]    last_d, last_q;
  logic                flag_d, flag_q;
  logic [TimeoutW-1:0] timeout_d, timeout_q;
  logic [TimeW-1:0]    elapsed;

  // next state of this slot
  always_comb begin
    last_d    = ctrl_i.beat ? now_d_i : last_q;
    flag_d    = flag_q | ctrl_i.beat;
    timeout_d = ctrl_i.cfg_we ? cfg_data_i : timeout_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      flag_q    <= 1'b0;
      timeout_q <= TimeoutReset;
    end else begin
      last_q    <= last_d;
      flag_q    <= flag_d;
      timeout_q <= timeout_d;
    end
  end

  // elapsed time wraps, expiry only once registered
  assign elapsed = now_d_i - last_d;

  always_comb begin
    stat_o.elapsed    = elapsed;
    stat_o.timeout    = timeout_q;
    stat_o.registered = flag_d;
    stat_o.expired    = flag_d && (elapsed > {{(TimeW-TimeoutW){1'b0}}, timeout_q});
  end

endmodule

// File: rtl/hbw_checker.sv
// ----------------------------------------------------------------------------
// hbw_checker - port-level checks for the heartbeat watchdog
// Responses to command beats, heartbeat response contents and health summary.
// ----------------------------------------------------------------------------
module hbw_checker #(
  parameter int unsigned MODULE_COUNT = hbw_pkg::ModuleCountDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input hbw_pkg::hbw_req_t             req_i,
  input logic                          done_o,
  input hbw_pkg::hbw_rsp_t             rsp_o
);
  import hbw_pkg::*;

  localparam logic [3:0] ModCnt = 4'(MODULE_COUNT);

  // every command beat taken gives a response
  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("response missing two clocks after command");

  // no response without a command beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("response without command");

  // a heartbeat on a watched module reports it fresh and registered
  a_beat_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.operation == OpBeat) &&
    ({1'b0, req_i.module_req} < ModCnt)
    |-> ##2 (rsp_o.elapsed_seconds == '0) && rsp_o.module_registered)
    else $error("heartbeat response not fresh");

  // health summary agrees with the expiry mask
  a_healthy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.all_healthy == (rsp_o.expired_mask == 8'd0)))
    else $error("all_healthy disagrees with expired_mask");

endmodule

bind multi_module_heartbeat_watchdog hbw_checker #(
  .MODULE_COUNT(MODULE_COUNT)
) u_hbw_checker (.*);

// File: dv/tb_multi_module_heartbeat_watchdog.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_module_heartbeat_watchdog - self-checking bench for the watchdog
// Drives tick, heartbeat and query commands with random gaps, and reprograms
// the module timeouts between phases while the block is idle. A scoreboard
// class keeps its own copy of the clock, stamps, flags and timeouts, predicts
// each status beat and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_multi_module_heartbeat_watchdog;
  import hbw_pkg::*;

  localparam int unsigned ModCount    = ModuleCountDef;
  localparam logic [1:0]  OpSpare     = 2'd3;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned MaxReports  = 20;

  // expected status store and watchdog predictor
  class watchdog_scoreboard;
    int unsigned         mod_count;
    logic [TimeW-1:0]    now_sec;
    logic [TimeW-1:0]    stamp [MaxModules];
    bit                  reg_flag [MaxModules];
    logic [TimeoutW-1:0] tmo [MaxModules];
    hbw_rsp_t            status_q [$];
    int unsigned         errors, tick_cnt, beat_cnt, query_cnt, cfg_cnt, expired_cnt;

    function new(int unsigned count);
      mod_count = count;
      now_sec   = '0;
      foreach (stamp[i]) begin
        stamp[i]    = '0;
        reg_flag[i] = 1'b0;
        tmo[i]      = TimeoutReset;
      end
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    // timeout register write, indexes past the list are dropped
    function void write_timeout(logic [CfgIdxW-1:0] idx, logic [TimeoutW-1:0] data);
      cfg_cnt++;
      if (idx < MaxModules) tmo[idx[2:0]] = data;
    endfunction

    // apply one command and queue the status it should produce
    function void log_command(hbw_req_t cmd);
      hbw_rsp_t         s;
      logic [7:0]       mask;
      logic [TimeW-1:0] el;
      int unsigned      m;
      m = 32'(cmd.module_req);
      case (cmd.operation)
        OpTick: begin
          now_sec = now_sec + TimeW'(1);
          tick_cnt++;
        end
        OpBeat: begin
          beat_cnt++;
          if (m < mod_count) begin
            stamp[m]    = now_sec;
            reg_flag[m] = 1'b1;
          end
        end
        default: query_cnt++;
      endcase
      mask = '0;
      for (int unsigned i = 0; i < MaxModules; i++) begin
        el = now_sec - stamp[i];
        if (i < mod_count && reg_flag[i] && el > {16'd0, tmo[i]}) mask[i] = 1'b1;
      end
      s = '0;
      if (m < mod_count) begin
        s.elapsed_seconds   = now_sec - stamp[m];
        s.module_timeout    = tmo[m];
        s.module_registered = reg_flag[m];
      end
      s.expired_mask = mask;
      s.all_healthy  = (mask == '0);
      if (mask != '0) expired_cnt++;
      status_q.push_back(s);
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] got);
      if (got !== exp) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, got);
      end
    endfunction

    // compare one returned status beat with the oldest expectation
    function void check_status(hbw_rsp_t got);
      hbw_rsp_t exp;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: status beat with nothing expected, expected none, got %h",
                   $time, got);
        return;
      end
      exp = status_q.pop_front();
      check_field("elapsed_seconds", exp.elapsed_seconds, got.elapsed_seconds);
      check_field("module_timeout", 32'(exp.module_timeout), 32'(got.module_timeout));
      check_field("module_registered", 32'(exp.module_registered),
                  32'(got.module_registered));
      check_field("expired_mask", 32'(exp.expired_mask), 32'(got.expired_mask));
      check_field("all_healthy", 32'(exp.all_healthy), 32'(got.all_healthy));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  hbw_req_t            req_i       = '0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [TimeoutW-1:0] cfg_data_i  = '0;
  logic                busy_o, done_o, cfg_ready_o;
  hbw_rsp_t            rsp_o;

  watchdog_scoreboard sb;
  bit                 no_gaps;

  multi_module_heartbeat_watchdog #(
    .MODULE_COUNT(ModCount)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // command beats taken by the block
  always @(posedge clk_i) begin
    if (rst_ni && start_i && busy_o === 1'b0) sb.log_command(req_i);
  end

  // status beats, valid for a single cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_status(rsp_o);
  end

  // timeout register writes
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o === 1'b1) sb.write_timeout(cfg_index_i, cfg_data_i);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [2:0] mod);
    int unsigned gap;
    start_i          <= 1'b1;
    req_i.operation  <= op;
    req_i.module_req <= mod;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [TimeoutW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // let every outstanding status beat come back, plus pipeline slack
  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // new timeout setting for all modules, sometimes with a stray index
  task automatic program_timeouts(int unsigned kind);
    int unsigned v;
    for (int unsigned i = 0; i < MaxModules; i++) begin
      case (kind)
        0: v = $urandom_range(0, 25);
        1: begin
          case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 1;
            2: v = 16'hFFFF;
            default: v = $urandom_range(2, 40);
          endcase
        end
        2: v = $urandom_range(0, 16'hFFFF);
        default: v = TimeoutReset;
      endcase
      cfg_write(CfgIdxW'(i), TimeoutW'(v));
    end
    if ($urandom_range(0, 1) == 1)
      cfg_write(CfgIdxW'($urandom_range(MaxModules, 255)), TimeoutW'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic send_random_cmd();
    int unsigned r;
    logic [1:0]  op;
    r = $urandom_range(0, 99);
    if (r < 45)      op = OpTick;
    else if (r < 75) op = OpBeat;
    else if (r < 90) op = OpQuery;
    else             op = OpSpare;
    send_cmd(op, 3'($urandom_range(0, 7)));
  endtask

  initial begin
    sb = new(ModCount);
    no_gaps = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: unregistered modules, default timeouts, spare code
    send_cmd(OpQuery, 3'd0);
    send_cmd(OpSpare, 3'd7);
    send_cmd(OpBeat,  3'd2);
    send_cmd(OpTick,  3'd2);
    send_cmd(OpBeat,  3'd5);
    send_cmd(OpQuery, 3'd6);
    wait_idle();

    // extreme timeouts, then walk modules in and out of expiry
    cfg_write(8'd0, 16'd0);
    cfg_write(8'd1, 16'hFFFF);
    cfg_write(8'd2, 16'd1);
    cfg_write(8'd3, 16'hFFFF);
    cfg_write(8'd4, 16'd0);
    cfg_write(8'd5, 16'd2);
    cfg_write(8'd6, TimeoutReset);
    cfg_write(8'd7, 16'd0);
    cfg_write(8'd200, 16'd5);
    cfg_write(8'd255, 16'hFFFF);
    send_cmd(OpBeat,  3'd0);
    send_cmd(OpTick,  3'd0);
    send_cmd(OpTick,  3'd5);
    send_cmd(OpTick,  3'd5);
    send_cmd(OpBeat,  3'd0);
    send_cmd(OpBeat,  3'd2);
    send_cmd(OpBeat,  3'd5);
    send_cmd(OpQuery, 3'd1);
    send_cmd(OpBeat,  3'd1);
    send_cmd(OpTick,  3'd1);
    send_cmd(OpSpare, 3'd3);
    send_cmd(OpBeat,  3'd7);
    send_cmd(OpBeat,  3'd4);
    send_cmd(OpTick,  3'd4);
    send_cmd(OpBeat,  3'd3);
    send_cmd(OpQuery, 3'd7);
    wait_idle();

    // random phases, each under its own timeout setting
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      program_timeouts(p % 4);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) send_random_cmd();
      wait_idle();
    end

    $display("ran %0d ticks, %0d heartbeats and %0d queries or spare codes",
             sb.tick_cnt, sb.beat_cnt, sb.query_cnt);
    $display("%0d timeout writes; %0d status beats showed an expired module",
             sb.cfg_cnt, sb.expired_cnt);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("timeout, status beats still outstanding");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
